// File: sv/tcce_pkg.sv
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CELL_W = 16;
  localparam int MEM_AW = 16;
  localparam int LIN_W  = 17;

  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] RESET_ATTR  = 8'h07;
  localparam logic [7:0] RESET_TAB   = 8'd8;

  localparam logic [2:0] REQ_PUT    = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_CURSOR = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;
  localparam logic [2:0] REQ_SCROLL = 3'd5;

  localparam logic REG_TEXT_ATTR = 1'b0;
  localparam logic REG_TAB_SIZE  = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [7:0] cell_attr;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] scroll_lines;
  } in_req_t;

  typedef struct packed {
    logic [14:0] cursor_position;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } out_res_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } mem_rd_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_TABDIV,
    S_TAB,
    S_WRAP,
    S_COPY,
    S_FILL,
    S_DONE
  } eng_state_t;

endpackage

// File: sv/tcce_cell_mem.sv
`timescale 1ns / 1ps

module tcce_cell_mem #(
  parameter int DEPTH = tcce_pkg::DEF_COLUMNS * tcce_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  tcce_pkg::mem_wr_t             wr,
  input  tcce_pkg::mem_rd_t             rd,
  output logic [tcce_pkg::CELL_W-1:0]   rd_data
);
  import tcce_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  logic [CELL_W-1:0] cell_ram [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cell_ram[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= cell_ram[rd.addr[ADDR_W-1:0]];
    end
  end

endmodule

// File: sv/tcce_tab_rem.sv
`timescale 1ns / 1ps

// column modulo tab size, one quotient bit per cycle
module tcce_tab_rem (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [8:0] divisor,
  output logic       done,
  output logic [8:0] rem
);
  import tcce_pkg::*;

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] dvd_r, dvd_nxt;
  logic [8:0] dsr_r, dsr_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [9:0] shifted;
  logic [9:0] diff;

  always_comb begin
    shifted  = {rem_r, dvd_r[7]};
    diff     = shifted - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = 3'd0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = 9'd0;
    end else if (busy_r) begin
      rem_nxt = (shifted >= {1'b0, dsr_r}) ? diff[8:0] : shifted[8:0];
      dvd_nxt = {dvd_r[6:0], 1'b0};
      bit_nxt = bit_r + 3'd1;
      if (bit_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: sv/text_console_char_engine_top.sv
`timescale 1ns / 1ps

// Text console engine: a ROWS x COLUMNS store of {attribute, character} cells plus a cursor,
// one request at a time, one result per request. After reset the cell store is swept to blanks
// with attribute 0x07, one cell per cycle with in_ready low; config writes are taken during the
// sweep. A tab put char waits on the bit-serial remainder unit, then writes blanks up to the
// next tab stop or the row end. Clear blanks every cell through the memory write port; a
// scroll by n copies through the read and write ports, then blank fills (a scroll by ROWS or
// more only fills), and a put char that runs off the bottom row pays a scroll by one row.
module text_console_char_engine_top #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcce_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output tcce_pkg::out_res_t out_res,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import tcce_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  eng_state_t        state_r, state_nxt;
  in_req_t           req_r, req_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [7:0]        attr_r, attr_nxt;
  logic [7:0]        tab_r, tab_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  off_r, off_nxt;
  logic [CELL_W-1:0] blank_r, blank_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [8:0]        tcnt_r, tcnt_nxt;
  logic [7:0]        rchar_r, rchar_nxt;
  logic [7:0]        rattr_r, rattr_nxt;
  out_res_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [CELL_W-1:0] mem_rd_data;

  logic              tab_start;
  logic              tab_done;
  logic [8:0]        tab_rem;
  logic [8:0]        tsz;

  logic [7:0]        mul_row;
  logic [7:0]        mul_col;
  logic [LIN_W-1:0]  lin;
  logic              req_on;
  logic              cur_on;

  tcce_cell_mem #(
    .DEPTH (CELL_COUNT)
  ) u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

  tcce_tab_rem u_tab (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tab_start),
    .dividend (col_r),
    .divisor  (tsz),
    .done     (tab_done),
    .rem      (tab_rem)
  );

  assign tsz    = (tab_r == 8'd0) ? 9'd256 : {1'b0, tab_r};
  assign req_on = (req_r.col < 8'(COLUMNS)) && (req_r.row < 8'(ROWS));
  assign cur_on = (col_r < 8'(COLUMNS)) && (row_r < 8'(ROWS));

  // shared row * COLUMNS + col
  always_comb begin
    mul_row = req_r.row;
    mul_col = req_r.col;
    if (state_r == S_DONE || req_r.req_type == REQ_PUT) begin
      mul_row = row_r;
      mul_col = col_r;
    end else if (req_r.req_type == REQ_SCROLL) begin
      mul_row = req_r.scroll_lines;
      mul_col = 8'd0;
    end
  end

  assign lin = LIN_W'(mul_row) * LIN_W'(COLUMNS) + LIN_W'(mul_col);

  always_comb begin
    logic [7:0] wrow;
    logic       rd_go;
    wrow          = row_r;
    rd_go         = 1'b0;
    state_nxt     = state_r;
    req_nxt       = req_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    attr_nxt      = attr_r;
    tab_nxt       = tab_r;
    ptr_nxt       = ptr_r;
    off_nxt       = off_r;
    blank_nxt     = blank_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    tcnt_nxt      = tcnt_r;
    rchar_nxt     = rchar_r;
    rattr_nxt     = rattr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_wr        = '0;
    mem_rd        = '0;
    tab_start     = 1'b0;

    case (state_r)
      S_INIT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = MEM_AW'(ptr_r);
        mem_wr.data = blank_r;
        ptr_nxt     = ptr_r + CNT_W'(1);
        if (ptr_r == CNT_W'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rchar_nxt = 8'd0;
        rattr_nxt = 8'd0;
        state_nxt = S_DONE;
        case (req_r.req_type)
          REQ_PUT: begin
            if (cur_on) begin
              ptr_nxt = CNT_W'(lin);
              if (req_r.char_code == CHR_NEWLINE) begin
                col_nxt   = 8'd0;
                row_nxt   = row_r + 8'd1;
                state_nxt = S_WRAP;
              end else if (req_r.char_code == CHR_TAB) begin
                tab_start = 1'b1;
                state_nxt = S_TABDIV;
              end else begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = MEM_AW'(lin);
                mem_wr.data = {attr_r, req_r.char_code};
                col_nxt     = col_r + 8'd1;
                state_nxt   = S_WRAP;
              end
            end
          end
          REQ_WRITE: begin
            if (req_on) begin
              mem_wr.en   = 1'b1;
              mem_wr.addr = MEM_AW'(lin);
              mem_wr.data = {req_r.cell_attr, req_r.char_code};
            end
          end
          REQ_READ: begin
            if (req_on) begin
              mem_rd.en   = 1'b1;
              mem_rd.addr = MEM_AW'(lin);
              state_nxt   = S_RDWAIT;
            end
          end
          REQ_CURSOR: begin
            col_nxt = req_r.col;
            row_nxt = req_r.row;
          end
          REQ_CLEAR: begin
            blank_nxt = {attr_r, CHR_SPACE};
            ptr_nxt   = '0;
            col_nxt   = 8'd0;
            row_nxt   = 8'd0;
            state_nxt = S_FILL;
          end
          REQ_SCROLL: begin
            blank_nxt = {attr_r, CHR_SPACE};
            if (req_r.scroll_lines >= 8'(ROWS)) begin
              ptr_nxt   = '0;
              col_nxt   = 8'd0;
              row_nxt   = 8'd0;
              state_nxt = S_FILL;
            end else if (req_r.scroll_lines != 8'd0) begin
              off_nxt   = CNT_W'(lin);
              ptr_nxt   = CNT_W'(lin);
              row_nxt   = (row_r >= req_r.scroll_lines) ? row_r - req_r.scroll_lines : 8'd0;
              state_nxt = S_COPY;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        rchar_nxt = mem_rd_data[7:0];
        rattr_nxt = mem_rd_data[15:8];
        state_nxt = S_DONE;
      end
      S_TABDIV: begin
        if (tab_done) begin
          tcnt_nxt  = tsz - tab_rem;
          state_nxt = S_TAB;
        end
      end
      S_TAB: begin
        if (tcnt_r != 9'd0 && col_r < 8'(COLUMNS)) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = MEM_AW'(ptr_r);
          mem_wr.data = {attr_r, CHR_SPACE};
          ptr_nxt     = ptr_r + CNT_W'(1);
          col_nxt     = col_r + 8'd1;
          tcnt_nxt    = tcnt_r - 9'd1;
        end else begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        if (col_r >= 8'(COLUMNS)) begin
          col_nxt = 8'd0;
          wrow    = row_r + 8'd1;
        end
        row_nxt   = wrow;
        state_nxt = S_DONE;
        if (wrow >= 8'(ROWS)) begin
          row_nxt   = 8'(ROWS - 1);
          off_nxt   = CNT_W'(COLUMNS);
          ptr_nxt   = CNT_W'(COLUMNS);
          blank_nxt = {attr_r, CHR_SPACE};
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        rd_go         = (ptr_r != CNT_W'(CELL_COUNT));
        mem_rd.en     = rd_go;
        mem_rd.addr   = MEM_AW'(ptr_r);
        pend_nxt      = rd_go;
        pend_addr_nxt = ADDR_W'(ptr_r - off_r);
        mem_wr.en     = pend_r;
        mem_wr.addr   = MEM_AW'(pend_addr_r);
        mem_wr.data   = mem_rd_data;
        if (rd_go) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end else if (!pend_r) begin
          ptr_nxt   = CNT_W'(CELL_COUNT) - off_r;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = MEM_AW'(ptr_r);
        mem_wr.data = blank_r;
        ptr_nxt     = ptr_r + CNT_W'(1);
        if (ptr_r == CNT_W'(CELL_COUNT - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.cursor_position = lin[14:0];
          out_nxt.read_char       = rchar_r;
          out_nxt.read_attr       = rattr_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_TEXT_ATTR: attr_nxt = cfg_data;
        REG_TAB_SIZE:  tab_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
      attr_r      <= RESET_ATTR;
      tab_r       <= RESET_TAB;
      ptr_r       <= '0;
      blank_r     <= {RESET_ATTR, CHR_SPACE};
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      attr_r      <= attr_nxt;
      tab_r       <= tab_nxt;
      ptr_r       <= ptr_nxt;
      blank_r     <= blank_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    off_r       <= off_nxt;
    pend_addr_r <= pend_addr_nxt;
    tcnt_r      <= tcnt_nxt;
    rchar_r     <= rchar_nxt;
    rattr_r     <= rattr_nxt;
    out_r       <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> (int'(mem_wr.addr) < CELL_COUNT))
    else $error("cell write outside the screen");

  a_copy_read_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd.en && mem_wr.en) |-> (mem_rd.addr > mem_wr.addr))
    else $error("scroll copy read does not lead the write");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_tab_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    tab_done |-> (state_r == S_TABDIV))
    else $error("tab remainder finished outside the tab step");

endmodule
